/* design/texture_sampler_nearest_bilinear_core_defines.svh */
// Assertion macros used by the checker file
`ifndef TEXTURE_SAMPLER_NEAREST_BILINEAR_CORE_DEFINES_SVH
`define TEXTURE_SAMPLER_NEAREST_BILINEAR_CORE_DEFINES_SVH

`define TSNB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define TSNB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/tsnb_pkg.sv */
package tsnb_pkg;
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam int SIZE_REG_W      = 9;
  localparam int COORD_W         = 16;
  localparam int COLOR_W         = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;
endpackage

/* design/tsnb_ram.sv */
module tsnb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/texture_sampler_nearest_bilinear_core.sv */
// A sample passes the v1, v2 and v3 registers to done; a write causes no result.
// Throughput: one item per cycle, any mix of writes and samples.
// Texels live in four banks split by x and y parity, so all four bilinear
// neighbors are read from the banks together; a write goes to one bank.
// Reset clears the pipeline valid bits and sets size regs to 256, filter to 0.
// Texel contents are undefined after reset until written.
module texture_sampler_nearest_bilinear_core #(
  parameter int MAX_WIDTH   = tsnb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = tsnb_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = tsnb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [tsnb_pkg::COORD_W-1:0]  coord_u,
  input  logic [tsnb_pkg::COORD_W-1:0]  coord_v,
  input  logic [tsnb_pkg::COLOR_W-1:0]  write_color,
  output logic                          done,
  output logic [tsnb_pkg::COLOR_W-1:0]  sample_color,
  input  logic                          cfg_we,
  input  logic [tsnb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsnb_pkg::SIZE_REG_W-1:0] cfg_data
);
  import tsnb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int SW = (XW > YW ? XW : YW) + 1;
  localparam int PW = COORD_W + SW;
  localparam int HXW = (XW > 1) ? XW - 1 : 1;
  localparam int HYW = (YW > 1) ? YW - 1 : 1;
  localparam int BDEPTH = (1 << HXW) * (1 << HYW);
  localparam int BAW = HXW + HYW;
  localparam int S = 1 << WEIGHT_BITS;
  localparam int CW = 8 + WEIGHT_BITS + 1;

  logic [SIZE_REG_W-1:0] image_width, image_height;
  logic                  filter_mode;
  logic [SW-1:0]         eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_REG_W'(256);
      image_height <= SIZE_REG_W'(256);
      filter_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_FILTER: filter_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) eff_w = SW'(1);
    else if ({{SW{1'b0}}, image_width} > (SW + SIZE_REG_W)'(MAX_WIDTH))
      eff_w = SW'(MAX_WIDTH);
    else eff_w = SW'(image_width);
    if (image_height == '0) eff_h = SW'(1);
    else if ({{SW{1'b0}}, image_height} > (SW + SIZE_REG_W)'(MAX_HEIGHT))
      eff_h = SW'(MAX_HEIGHT);
    else eff_h = SW'(image_height);
  end

  assign busy = 1'b0;

  // stage 1: scale coordinates
  logic              v1, f1;
  logic [PW-1:0]     pu1, pv1;
  logic [COLOR_W-1:0] wc1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    f1  <= func;
    pu1 <= PW'(coord_u) * PW'(eff_w);
    pv1 <= PW'(coord_v) * PW'(eff_h);
    wc1 <= write_color;
  end

  // stage 2: neighbor indices and bank addressing
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [WEIGHT_BITS-1:0] tx, ty;
  logic bil;
  always_comb begin
    x0 = XW'(pu1 >> COORD_W);
    y0 = YW'(pv1 >> COORD_W);
    x1 = ((SW'(x0) + SW'(1)) < eff_w) ? XW'(x0 + XW'(1)) : XW'(eff_w - SW'(1));
    y1 = ((SW'(y0) + SW'(1)) < eff_h) ? YW'(y0 + YW'(1)) : YW'(eff_h - SW'(1));
    tx = pu1[COORD_W-1 -: WEIGHT_BITS];
    ty = pv1[COORD_W-1 -: WEIGHT_BITS];
    bil = filter_mode;
  end

  logic [BAW-1:0] raddr [4];
  logic [BAW-1:0] waddr;
  logic [3:0]     wen;
  logic [1:0]     sel [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [XW-1:0] xs;
      logic [YW-1:0] ys;
      xs = (x0[0] == b[0]) ? x0 : x1;
      ys = (y0[0] == b[1]) ? y0 : y1;
      raddr[b] = {HYW'(ys >> 1), HXW'(xs >> 1)};
    end
    sel[0] = {y0[0], x0[0]};
    sel[1] = {y0[0], x1[0]};
    sel[2] = {y1[0], x0[0]};
    sel[3] = {y1[0], x1[0]};
    waddr = {HYW'(y0 >> 1), HXW'(x0 >> 1)};
    for (int b = 0; b < 4; b++)
      wen[b] = v1 && (f1 == FUNC_WRITE) && ({y0[0], x0[0]} == 2'(b));
  end

  logic [COLOR_W-1:0] rd [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    tsnb_ram #(.WIDTH(COLOR_W), .DEPTH(BDEPTH)) u_ram (
      .clk  (clk),
      .we   (wen[b]),
      .waddr(waddr),
      .wdata(wc1),
      .raddr(raddr[b]),
      .rdata(rd[b])
    );
  end

  logic v2, bil2;
  logic [1:0] sel2 [4];
  logic [WEIGHT_BITS-1:0] tx2, ty2, ty3;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1 && (f1 == FUNC_SAMPLE);
    bil2 <= bil;
    sel2 <= sel;
    tx2 <= tx;
    ty2 <= ty;
  end

  // stage 3: horizontal blend
  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [WEIGHT_BITS-1:0] t);
    logic [CW-1:0] acc;
    acc = CW'(a) * CW'(S - int'(t)) + CW'(b) * CW'(t) + CW'(S / 2);
    return 8'(acc >> WEIGHT_BITS);
  endfunction

  logic [COLOR_W-1:0] t00, t10, t01, t11;
  assign t00 = rd[sel2[0]];
  assign t10 = rd[sel2[1]];
  assign t01 = rd[sel2[2]];
  assign t11 = rd[sel2[3]];

  logic v3, bil3;
  logic [COLOR_W-1:0] top3, bot3, near3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    bil3  <= bil2;
    ty3   <= ty2;
    near3 <= t00;
    for (int c = 0; c < 4; c++) begin
      top3[c*8 +: 8] <= lerp(t00[c*8 +: 8], t10[c*8 +: 8], tx2);
      bot3[c*8 +: 8] <= lerp(t01[c*8 +: 8], t11[c*8 +: 8], tx2);
    end
  end

  // stage 4: vertical blend or nearest texel, and output
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v3;
    for (int c = 0; c < 4; c++)
      sample_color[c*8 +: 8] <= bil3 ? lerp(top3[c*8 +: 8], bot3[c*8 +: 8], ty3)
                                     : near3[c*8 +: 8];
  end
endmodule

/* design/tsnb_checker.sv */
`include "texture_sampler_nearest_bilinear_core_defines.svh"
module tsnb_props (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);
  `TSNB_ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy)
  `TSNB_ASSERT_NEXT(a_write_no_result, clk, rst, start && func, ##3 !done)
  `TSNB_ASSERT_IMPL(a_done_has_sample, clk, rst, done && !$past(rst, 4), $past(start && !func, 4))
  `TSNB_ASSERT_NEXT(a_sample_done, clk, rst, start && !func, ##3 done)
endmodule

bind texture_sampler_nearest_bilinear_core tsnb_props u_tsnb_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .done(done)
);
